@@ sv/rsm_pkg.sv @@
// Shared types and codes for the random sample multiset block.
package rsm_pkg;

   localparam int VALUE_W   = 32;
   localparam int RAND_W    = 32;
   localparam int DIV_CNT_W = $clog2(RAND_W);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [VALUE_W-1:0] item_value;
      logic [RAND_W-1:0]         random_word;
   } req_type;

   typedef struct packed {
      logic                      answer_flag;
      logic signed [VALUE_W-1:0] sampled_value;
      logic [1:0]                status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic scan_start;
      logic scan_run;
      logic wr_insert;
      logic rd_last;
      logic wr_remove;
      logic div_start;
      logic div_run;
      logic rd_sample;
      logic load_rsp;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       scan_done;
      logic       found;
      logic       full;
      logic       empty;
      logic       div_done;
   } dp_status_type;

endpackage

@@ sv/rsm_dp.sv @@
// Datapath: entry store, count, scan compare, remainder unit and result register.
module rsm_dp #(
   parameter int CAPACITY = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsm_pkg::req_type       req_in,
   input  rsm_pkg::dp_cmd_type    cmd_in,
   output rsm_pkg::dp_status_type status_out,
   output logic                   rsp_valid_out,
   output rsm_pkg::rsp_type       rsp_out
);
   import rsm_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RAND_W - 1);

   logic [VALUE_W-1:0]   mem [CAPACITY];

   req_type              req_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        issue_ptr_ff;
   logic                 rd_valid_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic                 found_ff;
   logic [IW-1:0]        found_idx_ff;
   logic                 full_ff, empty_ff;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [RAND_W-1:0]    word_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [VALUE_W-1:0]   rd_data_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic                 rd_en, wr_en, scan_issue;
   logic [IW-1:0]        rd_addr, wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic [CW-1:0]        last_ptr;
   logic [CW:0]          shifted;

   assign last_ptr   = CW'(count_ff - 1'b1);
   assign scan_issue = cmd_in.scan_run && (issue_ptr_ff < count_ff);

   // single read port, shared by scan, last-entry fetch and sample fetch
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = issue_ptr_ff[IW-1:0];
      if (scan_issue) begin
         rd_en = 1'b1;
      end else if (cmd_in.rd_last) begin
         rd_en   = 1'b1;
         rd_addr = last_ptr[IW-1:0];
      end else if (cmd_in.rd_sample) begin
         rd_en   = 1'b1;
         rd_addr = rem_ff[IW-1:0];
      end
   end

   // insert appends at the count; remove moves the last entry into the hole
   always_comb begin
      wr_en   = cmd_in.wr_insert || cmd_in.wr_remove;
      wr_addr = cmd_in.wr_insert ? count_ff[IW-1:0] : found_idx_ff;
      wr_data = cmd_in.wr_insert ? $unsigned(req_ff.item_value) : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd_in.wr_insert) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (cmd_in.wr_remove) begin
         count_in = last_ptr;
      end
   end

   // restoring remainder step, one bit of the random word per cycle
   always_comb begin
      shifted = {rem_ff, word_ff[RAND_W-1]};
      if (shifted >= {1'b0, count_ff}) begin
         rem_in = CW'(shifted - {1'b0, count_ff});
      end else begin
         rem_in = shifted[CW-1:0];
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.command) inside
         CMD_INSERT: begin
            rsp_in.answer_flag = !found_ff;
            rsp_in.status      = full_ff ? ST_FULL : ST_OK;
         end
         CMD_REMOVE: begin
            rsp_in.answer_flag = found_ff;
         end
         CMD_SAMPLE: begin
            if (empty_ff) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.sampled_value = $signed(rd_data_ff);
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd_in.load_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.load_req) begin
         req_ff   <= req_in;
         full_ff  <= (count_ff == CW'(CAPACITY));
         empty_ff <= (count_ff == '0);
      end
      if (cmd_in.scan_start) begin
         issue_ptr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else if (cmd_in.scan_run) begin
         rd_valid_ff <= scan_issue;
         rd_idx_ff   <= issue_ptr_ff[IW-1:0];
         if (scan_issue) begin
            issue_ptr_ff <= CW'(issue_ptr_ff + 1'b1);
         end
         if (rd_valid_ff && !found_ff && (rd_data_ff == $unsigned(req_ff.item_value))) begin
            found_ff     <= 1'b1;
            found_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd_in.div_start) begin
         rem_ff     <= '0;
         word_ff    <= req_ff.random_word;
         div_cnt_ff <= '0;
      end else if (cmd_in.div_run) begin
         rem_ff     <= rem_in;
         word_ff    <= {word_ff[RAND_W-2:0], 1'b0};
         div_cnt_ff <= DIV_CNT_W'(div_cnt_ff + 1'b1);
      end
      if (cmd_in.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status_out.cmd       = req_ff.command;
   assign status_out.scan_done = (issue_ptr_ff >= count_ff) && !rd_valid_ff;
   assign status_out.found     = found_ff;
   assign status_out.full      = full_ff;
   assign status_out.empty     = empty_ff;
   assign status_out.div_done  = (div_cnt_ff == DIV_LAST);

   assign rsp_valid_out = rsp_valid_ff;
   assign rsp_out       = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_no_append_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_in.wr_insert |-> !full_ff && (count_ff < CW'(CAPACITY)))
      else $error("append while full");

   a_remove_needs_hit: assert property (@(posedge clock) disable iff (reset)
      cmd_in.wr_remove |-> found_ff && (count_ff != '0))
      else $error("remove write without a matching entry");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

endmodule

@@ sv/rsm_ctrl.sv @@
// Controller: sequences scan, remove move, remainder and result for each request.
module rsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rsm_pkg::dp_status_type status_in,
   output rsm_pkg::dp_cmd_type    cmd_out
);
   import rsm_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_SCAN    = 8'b0000_0100,
      S_LAST_RD = 8'b0000_1000,
      S_LAST_WR = 8'b0001_0000,
      S_DIV     = 8'b0010_0000,
      S_SAMP_RD = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd_out  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_out.load_req = 1'b1;
               state_in         = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status_in.cmd) inside
               CMD_INSERT, CMD_REMOVE: begin
                  cmd_out.scan_start = 1'b1;
                  state_in           = S_SCAN;
               end
               CMD_SAMPLE: begin
                  if (status_in.empty) begin
                     state_in = S_RESP;
                  end else begin
                     cmd_out.div_start = 1'b1;
                     state_in          = S_DIV;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SCAN: begin
            cmd_out.scan_run = 1'b1;
            if (status_in.scan_done) begin
               if (status_in.cmd == CMD_INSERT) begin
                  cmd_out.wr_insert = !status_in.full;
                  state_in          = S_RESP;
               end else if (status_in.found) begin
                  state_in = S_LAST_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_LAST_RD: begin
            cmd_out.rd_last = 1'b1;
            state_in        = S_LAST_WR;
         end
         S_LAST_WR: begin
            cmd_out.wr_remove = 1'b1;
            state_in          = S_RESP;
         end
         S_DIV: begin
            cmd_out.div_run = 1'b1;
            if (status_in.div_done) begin
               state_in = S_SAMP_RD;
            end
         end
         S_SAMP_RD: begin
            cmd_out.rd_sample = 1'b1;
            state_in          = S_RESP;
         end
         S_RESP: begin
            cmd_out.load_rsp = 1'b1;
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && (state_ff == S_DECODE))
      else $error("request accepted but controller not busy");

   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |=> !busy)
      else $error("controller did not return to idle after result");

   a_remove_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LAST_RD |-> status_in.found && (status_in.cmd == CMD_REMOVE))
      else $error("last-entry fetch outside a successful remove");

endmodule

@@ sv/random_sample_multiset.sv @@
// Top level of the random sample multiset: controller plus datapath.
// Per request: insert or remove scans every entry, a remove hit then moves the last entry into
//   the hole, a sample runs 32 remainder steps and a store read; empty samples and unused codes
//   go straight to the result. One request at a time: busy drops in the strobe cycle and the
//   next request is taken at the edge ending it; the scan is the part that grows with the count.
// Sync active-high reset clears count, controller and strobe, not the store; no receiver stall.
module random_sample_multiset #(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  rsm_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   output rsm_pkg::rsp_type rsp_data
);
   import rsm_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: decides which datapath step runs each cycle
   rsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status_in (dp_status),
      .cmd_out   (dp_cmd)
   );

   // store, count, scan comparator, remainder unit, result register
   rsm_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_in        (req_data),
      .cmd_in        (dp_cmd),
      .status_out    (dp_status),
      .rsp_valid_out (rsp_valid),
      .rsp_out       (rsp_data)
   );

endmodule
